@@ rtl/core/assert_macros.svh @@
// assertion helpers for the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// clocked check, disabled while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ rtl/core/itc_pkg.sv @@
`default_nettype none

package itc_pkg;

  localparam int NUM_CHAN = 2;

  // transaction kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // port offsets
  localparam logic [1:0] PORT_CNT0 = 2'd0;
  localparam logic [1:0] PORT_CNT1 = 2'd1;
  localparam logic [1:0] PORT_CNT2 = 2'd2;
  localparam logic [1:0] PORT_CTRL = 2'd3;

  // control word select field
  localparam logic [1:0] SEL_CNT0     = 2'd0;
  localparam logic [1:0] SEL_CNT1     = 2'd1;
  localparam logic [1:0] SEL_CNT2     = 2'd2;
  localparam logic [1:0] SEL_READBACK = 2'd3;

  // access field: latch-only command
  localparam logic [1:0] ACCESS_LATCH = 2'd0;
  // access field as reported in status
  localparam logic [1:0] ACCESS_TWO_BYTES = 2'd3;

  // per channel: bus port, control select and read-back select bit
  localparam logic [1:0] CHAN_PORT  [NUM_CHAN] = '{PORT_CNT0, PORT_CNT2};
  localparam logic [1:0] CHAN_SEL   [NUM_CHAN] = '{SEL_CNT0, SEL_CNT2};
  localparam logic [2:0] CHAN_RB_BIT[NUM_CHAN] = '{3'd1, 3'd3};

  typedef struct packed {
    logic [15:0] live;
    logic [15:0] reload;
    logic [7:0]  low_hold;
    logic [2:0]  mode;
    logic        out_lvl;
    logic        wr_high;
    logic        load_pend;
    logic        null_cnt;
    logic [15:0] lat_cnt;
    logic        cnt_lat;
    logic [7:0]  lat_stat;
    logic        stat_lat;
    logic        rd_high;
  } chan_state_t;

  localparam chan_state_t CHAN_RESET = '{
    live: 16'd0, reload: 16'd0, low_hold: 8'd0, mode: 3'd0,
    out_lvl: 1'b1, wr_high: 1'b0, load_pend: 1'b0, null_cnt: 1'b1,
    lat_cnt: 16'd0, cnt_lat: 1'b0, lat_stat: 8'd0, stat_lat: 1'b0,
    rd_high: 1'b0
  };

endpackage

`default_nettype wire

@@ rtl/core/interval_timer_two_channel_unit.sv @@
// two-channel interval timer, 8254-style subset (counters 0 and 2,
// binary two-byte access, rate generator and square wave modes)
//
// input channel: one transaction per bus write, bus read or timer tick;
// in_tuser carries the kind, in_tdata the port offset and write byte.
// output channel: exactly one result transaction per input transaction,
// carrying the read byte (zero unless a counter port was read) and the
// two counter output levels after the input has taken effect.
//
// state updates at the accepting edge and the result sits in the output
// register on the next cycle. throughput is one transaction per cycle
// while out_tready keeps up; the output register frees in the same
// cycle it is taken, so in_tready only drops while a result waits and
// out_tready is low.
//
// reset (rst_n low, synchronous) returns both counters to their idle
// state: mode 0 (holding), output high, null count set, nothing
// latched, and empties the output register.
`default_nettype none
`include "assert_macros.svh"

module interval_timer_two_channel_unit
  import itc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,   // [1:0] port, [9:2] write_data, rest zero
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [15:0] out_tdata   // [7:0] read_data, [8] out_zero, [9] out_two
);

  chan_state_t st_r  [NUM_CHAN];
  chan_state_t st_nxt[NUM_CHAN];

  logic        out_valid_r;
  logic [9:0]  out_data_r;
  logic [9:0]  out_data_nxt;
  logic [7:0]  rd_nxt;

  logic        in_accept;
  logic [1:0]  in_kind;
  logic [1:0]  in_port;
  logic [7:0]  in_wdata;

  assign in_kind  = in_tuser;
  assign in_port  = in_tdata[1:0];
  assign in_wdata = in_tdata[9:2];

  // output register frees when taken, so a new transaction can enter
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

  // status byte: output, null count, access, mode as written, binary
  function automatic logic [7:0] status_of(input chan_state_t s);
    return {s.out_lvl, s.null_cnt, ACCESS_TWO_BYTES, s.mode, 1'b0};
  endfunction

  // one input clock on one counter; mode[1] clear means an unsupported
  // mode, mode[0] selects square wave (modes 6 and 7 alias to 2 and 3)
  function automatic chan_state_t tick_chan(input chan_state_t s);
    chan_state_t n;
    logic [15:0] step;
    n    = s;
    step = s.live[0] ? (s.out_lvl ? 16'd1 : 16'd3) : 16'd2;
    if (!s.mode[1]) begin
      n.out_lvl = 1'b1;
    end else if (s.load_pend) begin
      // new count taken on this tick
      n.live      = s.reload;
      n.load_pend = 1'b0;
      n.null_cnt  = 1'b0;
      if (!s.mode[0]) n.out_lvl = (s.reload != 16'd1);
    end else if (!s.null_cnt) begin
      if (!s.mode[0]) begin
        // rate generator: low for the one tick where count is one
        n.live    = (s.live == 16'd1) ? s.reload : s.live - 16'd1;
        n.out_lvl = (n.live != 16'd1);
      end else begin
        // square wave: step by two, odd counts stretch the high half
        if (s.live != 16'd0 && s.live <= step) begin
          n.out_lvl = !s.out_lvl;
          n.live    = s.reload;
        end else begin
          n.live = s.live - step;
        end
      end
    end
    return n;
  endfunction

  always_comb begin
    rd_nxt = 8'd0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      st_nxt[c] = st_r[c];
      unique case (in_kind)
        KIND_WRITE: begin
          if (in_port == PORT_CTRL) begin
            if (in_wdata[7:6] == SEL_READBACK) begin
              if (in_wdata[CHAN_RB_BIT[c]]) begin
                // a latch already held and not read is left alone
                if (!in_wdata[5] && !st_r[c].cnt_lat) begin
                  st_nxt[c].lat_cnt = st_r[c].live;
                  st_nxt[c].cnt_lat = 1'b1;
                end
                if (!in_wdata[4] && !st_r[c].stat_lat) begin
                  st_nxt[c].lat_stat = status_of(st_r[c]);
                  st_nxt[c].stat_lat = 1'b1;
                end
              end
            end else if (in_wdata[7:6] != SEL_CNT1 && in_wdata[5:4] != ACCESS_LATCH &&
                         in_wdata[7:6] == CHAN_SEL[c]) begin
              // program mode, counter holds until a full count arrives
              st_nxt[c].mode      = in_wdata[3:1];
              st_nxt[c].out_lvl   = 1'b1;
              st_nxt[c].null_cnt  = 1'b1;
              st_nxt[c].load_pend = 1'b0;
              st_nxt[c].wr_high   = 1'b0;
              st_nxt[c].rd_high   = 1'b0;
            end
          end else if (in_port == CHAN_PORT[c]) begin
            if (!st_r[c].wr_high) begin
              st_nxt[c].low_hold = in_wdata;
              st_nxt[c].wr_high  = 1'b1;
            end else begin
              st_nxt[c].reload    = {in_wdata, st_r[c].low_hold};
              st_nxt[c].wr_high   = 1'b0;
              st_nxt[c].load_pend = 1'b1;
              st_nxt[c].null_cnt  = 1'b1;
            end
          end
        end
        KIND_READ: begin
          if (in_port == CHAN_PORT[c]) begin
            if (st_r[c].stat_lat) begin
              rd_nxt             = st_r[c].lat_stat;
              st_nxt[c].stat_lat = 1'b0;
            end else begin
              if (st_r[c].cnt_lat) begin
                rd_nxt = st_r[c].rd_high ? st_r[c].lat_cnt[15:8] : st_r[c].lat_cnt[7:0];
                if (st_r[c].rd_high) st_nxt[c].cnt_lat = 1'b0;
              end else begin
                rd_nxt = st_r[c].rd_high ? st_r[c].live[15:8] : st_r[c].live[7:0];
              end
              st_nxt[c].rd_high = !st_r[c].rd_high;
            end
          end
        end
        KIND_TICK: begin
          st_nxt[c] = tick_chan(st_r[c]);
        end
        default: begin
          // unused kind: no effect
        end
      endcase
    end
    out_data_nxt = {st_nxt[1].out_lvl, st_nxt[0].out_lvl, rd_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CHAN; c++) st_r[c] <= CHAN_RESET;
    end else begin
      if (in_accept) begin
        out_valid_r <= 1'b1;
        for (int c = 0; c < NUM_CHAN; c++) st_r[c] <= st_nxt[c];
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) out_data_r <= out_data_nxt;
  end

  // every accepted transaction shows a result on the next cycle
  `ASSERT_CLK(a_result_follows, clk, rst_n, (in_tvalid && in_tready) |=> out_tvalid)
  // a counter in an unsupported mode keeps its output high
  `ASSERT_CLK(a_hold_high0, clk, rst_n, !st_r[0].mode[1] |-> st_r[0].out_lvl)
  `ASSERT_CLK(a_hold_high1, clk, rst_n, !st_r[1].mode[1] |-> st_r[1].out_lvl)
  // a pending load always comes with null count set
  `ASSERT_CLK(a_pend_null0, clk, rst_n, st_r[0].load_pend |-> st_r[0].null_cnt)
  `ASSERT_CLK(a_pend_null1, clk, rst_n, st_r[1].load_pend |-> st_r[1].null_cnt)

endmodule

`default_nettype wire
